// File: design/qedc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qedc_pkg
// Types, constants and the quadrature step table shared by the encoder
// detent counter modules.
// ----------------------------------------------------------------------------
package qedc_pkg;

  localparam int SLOTS        = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int ADDR_W       = 3;
  localparam int LIMIT_W      = 3;
  localparam int SUM_W        = 4;
  localparam int COUNT_W      = 8;

  localparam logic [ADDR_W-1:0]  ADDR_DETENT_THRESHOLD = 3'd0;
  localparam logic [LIMIT_W-1:0] THRESHOLD_RESET       = 3'd2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [3:0] pins_a;
    logic [3:0] pins_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count_ch0;
    logic signed [COUNT_W-1:0] count_ch1;
    logic signed [COUNT_W-1:0] count_ch2;
    logic signed [COUNT_W-1:0] count_ch3;
  } out_beat_t;

  typedef struct packed {
    logic               tick;
    logic               drain;
    logic               primed;
    logic [LIMIT_W-1:0] limit;
  } lane_ctrl_t;

  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
    return STEP_TABLE[idx];
  endfunction

endpackage
`default_nettype wire

// File: design/quad_encoder_detent_counter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quad_encoder_detent_counter_top
// Four-channel quadrature encoder front end with detent counting.
//
// Input beats on in_data/in_valid/in_ready carry a command bit and the A and
// B pin levels of every encoder. A tick beat is sampled by one lane per
// channel; it returns nothing. A drain beat returns one result beat on
// out_data/out_valid/out_ready holding every channel's signed detent count
// and clears the counts.
// Tick beats are taken every cycle, also while a result waits. A drain
// result appears in the cycle after its beat is accepted and stays in the
// output register until taken; a drain beat is held off only while that
// register is full and the receiver stalls, so one beat per cycle is
// sustained when out_ready is high.
// The detent_threshold register sits at byte address 0 of the APB port; a
// value of 0 acts as 1. Reset sets the threshold to 2, clears all counts,
// empties the output register and lets the first tick load the pin levels
// without counting.
// ----------------------------------------------------------------------------
module quad_encoder_detent_counter_top #(
  parameter int CHANNELS = qedc_pkg::CHANNELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qedc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire qedc_pkg::in_beat_t          in_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  output qedc_pkg::out_beat_t              out_data,
  output logic                             out_valid,
  input  wire logic                        out_ready
);
  import qedc_pkg::*;

  logic [LIMIT_W-1:0] detent_threshold;
  logic               primed;
  logic               accept;
  logic               tick;
  logic               drain;
  lane_ctrl_t         ctrl;
  logic [COUNT_W-1:0] counts [CHANNELS];

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DETENT_THRESHOLD) ? {29'd0, detent_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      detent_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_DETENT_THRESHOLD)) begin
      detent_threshold <= pwdata[LIMIT_W-1:0];
    end
  end

  assign in_ready = (in_data.cmd == CMD_TICK) || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (in_data.cmd == CMD_TICK);
  assign drain    = accept && (in_data.cmd == CMD_DRAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (tick) begin
      primed <= 1'b1;
    end
  end

  always_comb begin
    ctrl.tick   = tick;
    ctrl.drain  = drain;
    ctrl.primed = primed;
    ctrl.limit  = (detent_threshold == '0) ? LIMIT_W'(1) : detent_threshold;
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    qedc_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .level ({in_data.pins_b[g], in_data.pins_a[g]}),
      .count (counts[g])
    );
  end

  qedc_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .drain     (drain),
    .counts    (counts),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire

// File: design/qedc_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qedc_lane
// One encoder channel: two-sample level filter, quadrature step
// accumulation and the signed detent count.
// ----------------------------------------------------------------------------
module qedc_lane (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire qedc_pkg::lane_ctrl_t       ctrl,
  input  wire logic [1:0]                 level,
  output logic [qedc_pkg::COUNT_W-1:0]    count
);
  import qedc_pkg::*;

  logic [1:0]               last_sample;
  logic [1:0]               stable_level;
  logic signed [SUM_W-1:0]  half_step_sum;
  logic [COUNT_W-1:0]       detent_count;

  logic                     change;
  logic signed [SUM_W:0]    sum;
  logic signed [SUM_W:0]    lim;
  logic                     up;
  logic                     down;

  always_comb begin
    change = (level == last_sample) && (level != stable_level);
    sum    = {half_step_sum[SUM_W-1], half_step_sum}
           + (SUM_W+1)'(step_lookup({stable_level, level}));
    lim    = $signed({2'b00, ctrl.limit});
    up     = sum >= lim;
    down   = sum <= -lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample   <= '0;
      stable_level  <= '0;
      half_step_sum <= '0;
      detent_count  <= '0;
    end else if (ctrl.drain) begin
      detent_count <= '0;
    end else if (ctrl.tick) begin
      if (!ctrl.primed) begin
        last_sample  <= level;
        stable_level <= level;
      end else if (level != last_sample) begin
        last_sample <= level;
      end else if (change) begin
        stable_level <= level;
        if (up) begin
          half_step_sum <= '0;
          detent_count  <= detent_count + COUNT_W'(1);
        end else if (down) begin
          half_step_sum <= '0;
          detent_count  <= detent_count - COUNT_W'(1);
        end else begin
          half_step_sum <= sum[SUM_W-1:0];
        end
      end
    end
  end

  assign count = detent_count;

endmodule
`default_nettype wire

// File: design/qedc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qedc_merge
// Gathers the lane counts into one result beat on a drain and holds it
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module qedc_merge #(
  parameter int CHANNELS = qedc_pkg::CHANNELS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     drain,
  input  wire logic [qedc_pkg::COUNT_W-1:0] counts [CHANNELS],
  output qedc_pkg::out_beat_t           out_data,
  output logic                          out_valid,
  input  wire logic                     out_ready
);
  import qedc_pkg::*;

  logic [COUNT_W-1:0] slot [SLOTS];
  out_beat_t          result;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      slot[i] = '0;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      slot[i] = counts[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      result.count_ch0 <= $signed(slot[0]);
      result.count_ch1 <= $signed(slot[1]);
      result.count_ch2 <= $signed(slot[2]);
      result.count_ch3 <= $signed(slot[3]);
    end
  end

  assign out_data = result;

endmodule
`default_nettype wire

// File: dv/quad_encoder_detent_counter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_encoder_detent_counter_top_tb
// Self-checking bench for the four-channel encoder detent counter. Tick beats
// carry encoder pin levels and drain beats return the signed detent counts.
// A tracker class follows every accepted beat with its own debounce,
// half-step and detent state. It checks each drain result field by field.
// Stimulus runs a short directed sequence and then a long clockwise and
// counterclockwise sweep that wraps the counts. It then runs mixed random
// phases with every threshold setting, one-sample glitches, double jumps and
// raw pin noise, with random gaps on both channels.
// ----------------------------------------------------------------------------
module quad_encoder_detent_counter_top_tb;
  import qedc_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;

  // Level that follows each level in the clockwise direction (A in bit 0).
  localparam logic [1:0] CW_NEXT [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  // Clockwise ring of levels, indexed by wheel position.
  localparam logic [1:0] CW_ORDER [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

  class detent_tracker;
    logic [LIMIT_W-1:0] threshold;
    bit                 primed;
    logic [1:0]         last_level [SLOTS];
    logic [1:0]         settled [SLOTS];
    int                 half_steps [SLOTS];
    logic [COUNT_W-1:0] detents [SLOTS];
    out_beat_t          pending_counts [$];
    int                 errors;
    int                 ticks;
    int                 drains;

    function new();
      threshold = THRESHOLD_RESET;
      primed    = 1'b0;
      errors    = 0;
      ticks     = 0;
      drains    = 0;
      for (int ch = 0; ch < SLOTS; ch++) begin
        last_level[ch] = '0;
        settled[ch]    = '0;
        half_steps[ch] = 0;
        detents[ch]    = '0;
      end
    endfunction

    function int quarter_step(input logic [1:0] from, input logic [1:0] to);
      if (to == CW_NEXT[from]) return 1;
      if (from == CW_NEXT[to]) return -1;
      return 0;
    endfunction

    function void note_beat(input in_beat_t beat);
      logic [1:0] level;
      int         limit;
      out_beat_t  counts;
      if (beat.cmd == CMD_DRAIN) begin
        counts.count_ch0 = detents[0];
        counts.count_ch1 = detents[1];
        counts.count_ch2 = detents[2];
        counts.count_ch3 = detents[3];
        pending_counts.push_back(counts);
        for (int ch = 0; ch < SLOTS; ch++) detents[ch] = '0;
        drains++;
        return;
      end
      ticks++;
      limit = (threshold == '0) ? 1 : int'(threshold);
      for (int ch = 0; ch < SLOTS; ch++) begin
        level = {beat.pins_b[ch], beat.pins_a[ch]};
        if (!primed) begin
          last_level[ch] = level;
          settled[ch]    = level;
        end else if (level != last_level[ch]) begin
          last_level[ch] = level;
        end else if (level != settled[ch]) begin
          half_steps[ch] = half_steps[ch] + quarter_step(settled[ch], level);
          settled[ch]    = level;
          if (half_steps[ch] >= limit) begin
            half_steps[ch] = 0;
            detents[ch]    = detents[ch] + 8'd1;
          end else if (half_steps[ch] <= -limit) begin
            half_steps[ch] = 0;
            detents[ch]    = detents[ch] - 8'd1;
          end
        end
      end
      primed = 1'b1;
    endfunction

    function void check_counts(input out_beat_t got);
      logic [SLOTS*COUNT_W-1:0] want_bits;
      logic [SLOTS*COUNT_W-1:0] got_bits;
      logic [COUNT_W-1:0]       want_lane;
      logic [COUNT_W-1:0]       got_lane;
      got_bits = got;
      if (pending_counts.size() == 0) begin
        $display("%0t: result beat with no drain pending, expected none, actual %h",
                 $time, got_bits);
        errors++;
        return;
      end
      want_bits = pending_counts.pop_front();
      for (int ch = 0; ch < SLOTS; ch++) begin
        want_lane = want_bits[COUNT_W*(SLOTS-1-ch) +: COUNT_W];
        got_lane  = got_bits[COUNT_W*(SLOTS-1-ch) +: COUNT_W];
        if (want_lane !== got_lane) begin
          $display("%0t: count_ch%0d mismatch, expected %0d, actual %0d",
                   $time, ch, $signed(want_lane), $signed(got_lane));
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  in_beat_t           in_data;
  logic               in_valid;
  logic               in_ready;
  out_beat_t          out_data;
  logic               out_valid;
  logic               out_ready;

  detent_tracker      tracker;
  bit                 idling;
  bit                 hold_request;
  int                 quiet_cycles;
  int                 wheel_pos [SLOTS];
  int                 wheel_dir [SLOTS];

  always #1 clk = ~clk;

  quad_encoder_detent_counter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tracker.note_beat(in_data);
    if (!rst && out_valid && out_ready) tracker.check_counts(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("quad_encoder_detent_counter_top_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_beat_t levels_to_beat(input logic [2*SLOTS-1:0] lv);
    in_beat_t beat;
    beat.cmd = CMD_TICK;
    for (int ch = 0; ch < SLOTS; ch++) begin
      beat.pins_a[ch] = lv[2*ch];
      beat.pins_b[ch] = lv[2*ch+1];
    end
    return beat;
  endfunction

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic push_beat(input in_beat_t beat);
    if (idling && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 18));
    @(negedge clk);
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_drain();
    in_beat_t beat;
    beat.cmd    = CMD_DRAIN;
    beat.pins_a = 4'($urandom_range(0, 15));
    beat.pins_b = 4'($urandom_range(0, 15));
    push_beat(beat);
  endtask

  task automatic show_levels(input logic [2*SLOTS-1:0] lv, input int beats);
    repeat (beats) push_beat(levels_to_beat(lv));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input int value);
    logic [31:0] word;
    word = $urandom;
    word[LIMIT_W-1:0] = value[LIMIT_W-1:0];
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DETENT_THRESHOLD;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.threshold = value[LIMIT_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic directed_checks();
    send_drain();
    push_beat(levels_to_beat(8'hFF));
    show_levels(8'h00, 2);
    // Channels 0 and 1 turn one full cycle clockwise, 2 and 3 the other way.
    show_levels({2'd1, 2'd1, 2'd2, 2'd2}, 2);
    show_levels({2'd3, 2'd3, 2'd3, 2'd3}, 2);
    show_levels({2'd2, 2'd2, 2'd1, 2'd1}, 2);
    show_levels(8'h00, 2);
    show_levels({2'd2, 2'd1, 2'd3, 2'd2}, 1);
    show_levels(8'h00, 2);
    show_levels({2'd0, 2'd0, 2'd0, 2'd2}, 2);
    send_drain();
    send_drain();
    wheel_pos = '{1, 0, 0, 0};
  endtask

  task automatic run_sweep(input int beats);
    logic [2*SLOTS-1:0] lv;
    wheel_dir = '{1, 1, -1, 1};
    for (int i = 0; i < beats; i++) begin
      if (i % 2 == 0) begin
        for (int ch = 0; ch < SLOTS; ch++) begin
          if (ch == 3) wheel_dir[ch] = $urandom_range(0, 1) ? 1 : -1;
          wheel_pos[ch] = (wheel_pos[ch] + wheel_dir[ch] + 4) % 4;
        end
      end
      for (int ch = 0; ch < SLOTS; ch++) lv[2*ch +: 2] = CW_ORDER[wheel_pos[ch]];
      push_beat(levels_to_beat(lv));
    end
    send_drain();
  endtask

  task automatic run_mixed(input int beats, input int drain_odds);
    logic [2*SLOTS-1:0] lv;
    in_beat_t           beat;
    int                 pick;
    for (int ch = 0; ch < SLOTS; ch++) wheel_dir[ch] = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(1, drain_odds) == 1) begin
        send_drain();
      end else if ($urandom_range(0, 9) == 0) begin
        beat.cmd    = CMD_TICK;
        beat.pins_a = 4'($urandom_range(0, 15));
        beat.pins_b = 4'($urandom_range(0, 15));
        push_beat(beat);
      end else begin
        for (int ch = 0; ch < SLOTS; ch++) begin
          pick = $urandom_range(0, 99);
          if (pick < 20) begin
            wheel_pos[ch] = (wheel_pos[ch] + wheel_dir[ch] + 4) % 4;
          end else if (pick < 25) begin
            wheel_pos[ch] = (wheel_pos[ch] - wheel_dir[ch] + 4) % 4;
          end else if (pick < 28) begin
            wheel_pos[ch] = (wheel_pos[ch] + 2) % 4;
          end
          lv[2*ch +: 2] = CW_ORDER[wheel_pos[ch]];
          // A one-sample glitch shows a different level without moving the wheel.
          if (pick >= 28 && pick < 33) lv[2*ch +: 2] = lv[2*ch +: 2] ^ 2'($urandom_range(1, 3));
        end
        push_beat(levels_to_beat(lv));
      end
    end
  endtask

  initial begin
    int thresholds [8];
    tracker      = new();
    thresholds   = '{0, 4, 7, 1, 5, 6, 3, 2};
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_data      = '0;
    in_valid     = 1'b0;
    idling       = 1'b1;
    hold_request = 1'b0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_checks();
    settle();
    write_threshold(1);
    run_sweep(400);
    settle();
    foreach (thresholds[k]) begin
      write_threshold(thresholds[k]);
      if (k == 7) idling = 1'b0;
      if (thresholds[k] == 4) begin
        hold_request = 1'b1;
        run_mixed(100, 2);
      end else begin
        run_mixed(100, 8);
      end
      settle();
    end

    $display("Run covered %0d tick beats and %0d drain beats over thresholds 0 to 7,",
             tracker.ticks, tracker.drains);
    $display("including count wrap both ways, glitches, double jumps and a long output stall.");
    if (tracker.errors == 0 && tracker.pending_counts.size() == 0)
      $display("quad_encoder_detent_counter_top_tb passed");
    else
      $display("quad_encoder_detent_counter_top_tb failed");
    $finish;
  end

endmodule

// File: quad_encoder_detent_counter_top.f
design/qedc_pkg.sv
design/qedc_lane.sv
design/qedc_merge.sv
design/quad_encoder_detent_counter_top.sv
dv/quad_encoder_detent_counter_top_tb.sv
